FILE: rtl/arc_pkg.sv
// Shared types and constants for the ARP resolver cache.
`default_nettype none
package arc_pkg;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int TYPE_W = 16;
    localparam int TAG_W  = 8;
    localparam int LEN_W  = 11;
    localparam int OP_W   = 16;

    localparam int CACHE_ENTRIES_DEF = 8;
    localparam int MAX_PAYLOAD_DEF   = 1500;
    localparam int Q_DEPTH           = 2;

    localparam logic             FUNC_SEND  = 1'b1;
    localparam logic [OP_W-1:0]  OP_REQUEST = 16'd1;
    localparam logic [OP_W-1:0]  OP_REPLY   = 16'd2;
    localparam logic [MAC_W-1:0] BCAST_MAC  = '1;

    // Configuration register indexes; my_mac (index 1) is not held here,
    // outgoing ARP frames are built outside.
    localparam int   CFG_IDX_W = 1;
    localparam int   CFG_W     = MAC_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_IP = 1'b0;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_DATA,
        ACT_ARP_REQ,
        ACT_ARP_REPLY
    } t_action;

    typedef enum logic [1:0] {
        KIND_SEND,
        KIND_ARP_REQ,
        KIND_ARP_REPLY
    } t_kind;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

    typedef struct packed {
        logic              func;
        logic [OP_W-1:0]   arp_operation;
        logic [IP_W-1:0]   sender_ip;
        logic [MAC_W-1:0]  sender_mac;
        logic [IP_W-1:0]   target_ip;
        logic [IP_W-1:0]   dest_ip;
        logic [TYPE_W-1:0] frame_type;
        logic [TAG_W-1:0]  payload_tag;
        logic [LEN_W-1:0]  data_len;
    } t_in_item;

    typedef struct packed {
        t_action           action;
        logic [MAC_W-1:0]  out_mac;
        logic [IP_W-1:0]   out_ip;
        logic [TYPE_W-1:0] out_type;
        logic [TAG_W-1:0]  out_tag;
        logic [LEN_W-1:0]  out_len;
        logic              was_queued;
    } t_out_item;

    // Classified command handed from front to back.
    typedef struct packed {
        t_kind             kind;
        logic              to_us;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TYPE_W-1:0] ftype;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/arp_resolver_cache_core.sv
// Top level of the ARP resolver cache: config register, front, queue, back.
// An ARP request aimed at us reaches o_res through the front register, queue and result
// register; a send or reply result follows a linear slot scan that ends early on a hit.
// Busy is high one cycle per kept word while the queue has room; the back end takes no new
// word until the slot scan of the last one ends; the scan is linear over the one-port cache read.
// Reset clears valid bits, insert pointer, pending frame and queue; no clearing pass.
// Result words show for one cycle on o_res_valid; the receiver cannot stall them.
`default_nettype none
module arp_resolver_cache_core #(
    parameter int CACHE_ENTRIES = arc_pkg::CACHE_ENTRIES_DEF,
    parameter int MAX_PAYLOAD   = arc_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire arc_pkg::t_in_item             i_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [arc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [arc_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                               o_res_valid,
    output arc_pkg::t_out_item                 o_res
);
    import arc_pkg::*;

    logic [IP_W-1:0] r_my_ip;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    t_cmd            f_cmd;
    t_cmd            q_cmd;

    // only my_ip is held; a write to the MAC register is taken and dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_ip <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MY_IP: r_my_ip <= i_cfg_data[IP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    arc_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .i_my_ip (r_my_ip),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    arc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    arc_back #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

FILE: rtl/arc_front.sv
// Front end: takes one word, classifies it and drops ignored packets.
`default_nettype none
module arc_front #(
    parameter int MAX_PAYLOAD = arc_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire arc_pkg::t_in_item        i_item,
    input  wire logic [arc_pkg::IP_W-1:0] i_my_ip,
    input  wire logic                     i_full,
    output logic                          o_push,
    output arc_pkg::t_cmd                 o_cmd
);
    import arc_pkg::*;

    logic             r_valid;
    t_cmd             r_cmd;
    t_cmd             cmd;
    logic             keep;
    logic [LEN_W-1:0] len_clamped;

    always_comb begin
        if (32'(i_item.data_len) > MAX_PAYLOAD) begin
            len_clamped = LEN_W'(MAX_PAYLOAD);
        end else begin
            len_clamped = i_item.data_len;
        end
    end

    always_comb begin
        cmd.kind  = KIND_SEND;
        cmd.to_us = (i_item.target_ip == i_my_ip);
        cmd.ip    = i_item.sender_ip;
        cmd.mac   = i_item.sender_mac;
        cmd.ftype = i_item.frame_type;
        cmd.tag   = i_item.payload_tag;
        cmd.len   = len_clamped;
        keep      = 1'b0;
        if (i_item.func == FUNC_SEND) begin
            cmd.ip = i_item.dest_ip;
            keep   = 1'b1;
        end else if (i_item.arp_operation == OP_REQUEST) begin
            // answer only requests aimed at us
            cmd.kind = KIND_ARP_REQ;
            keep     = cmd.to_us;
        end else if (i_item.arp_operation == OP_REPLY) begin
            cmd.kind = KIND_ARP_REPLY;
            keep     = 1'b1;
        end
    end

    assign busy   = r_valid;
    assign o_push = r_valid && !i_full;
    assign o_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (start && !r_valid) begin
            r_valid <= keep;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_valid) begin
            r_cmd <= cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/arc_queue.sv
// Short command queue between front and back.
`default_nettype none
module arc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire arc_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output arc_pkg::t_cmd      o_cmd
);
    import arc_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(Q_DEPTH - 1);

    t_cmd          r_mem [Q_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == (AW + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/arc_back.sv
// Back end: cache scan, round-robin insert, pending frame and result word.
`default_nettype none
module arc_back #(
    parameter int CACHE_ENTRIES = arc_pkg::CACHE_ENTRIES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire arc_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_res_valid,
    output arc_pkg::t_out_item o_res
);
    import arc_pkg::*;

    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam logic [AW-1:0] LAST = AW'(CACHE_ENTRIES - 1);

    t_back_state              r_state, n_state;
    t_cmd                     r_cur, n_cur;
    logic [AW-1:0]            r_idx, n_idx;
    logic                     r_issue_done, n_issue_done;
    logic                     r_chk, n_chk;
    logic [AW-1:0]            r_chk_addr, n_chk_addr;
    logic [CACHE_ENTRIES-1:0] r_valid, n_valid;
    logic [AW-1:0]            r_next_slot, n_next_slot;
    logic [IP_W-1:0]          r_pend_ip, n_pend_ip;
    logic [TYPE_W-1:0]        r_pend_type, n_pend_type;
    logic [TAG_W-1:0]         r_pend_tag, n_pend_tag;
    logic [LEN_W-1:0]         r_pend_len, n_pend_len;
    logic                     r_res_valid, n_res_valid;
    t_out_item                r_res, n_res;

    logic [IP_W+MAC_W-1:0]    r_cache_mem [CACHE_ENTRIES];
    logic [IP_W-1:0]          r_rd_ip;
    logic [MAC_W-1:0]         r_rd_mac;

    logic                     hit_now;
    logic                     scan_end;
    logic                     mem_we;

    function automatic t_out_item f_res(
        input t_action           a,
        input logic [MAC_W-1:0]  mac,
        input logic [IP_W-1:0]   ip,
        input logic [TYPE_W-1:0] ty,
        input logic [TAG_W-1:0]  tg,
        input logic [LEN_W-1:0]  ln,
        input logic              q
    );
        t_out_item r;
        r.action     = a;
        r.out_mac    = mac;
        r.out_ip     = ip;
        r.out_type   = ty;
        r.out_tag    = tg;
        r.out_len    = ln;
        r.was_queued = q;
        return r;
    endfunction

    assign hit_now  = r_chk && r_valid[r_chk_addr] && (r_rd_ip == r_cur.ip);
    assign scan_end = r_chk && (hit_now || (r_chk_addr == LAST));

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_idx        = r_idx;
        n_issue_done = r_issue_done;
        n_chk        = 1'b0;
        n_chk_addr   = r_chk_addr;
        n_valid      = r_valid;
        n_next_slot  = r_next_slot;
        n_pend_ip    = r_pend_ip;
        n_pend_type  = r_pend_type;
        n_pend_tag   = r_pend_tag;
        n_pend_len   = r_pend_len;
        n_res_valid  = 1'b0;
        n_res        = r_res;
        mem_we       = 1'b0;
        o_pop        = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop        = 1'b1;
                    n_cur        = i_cmd;
                    n_idx        = '0;
                    n_issue_done = 1'b0;
                    if (i_cmd.kind == KIND_ARP_REQ) begin
                        // answers need no lookup
                        n_res_valid = 1'b1;
                        n_res = f_res(ACT_ARP_REPLY, i_cmd.mac, i_cmd.ip,
                                      '0, '0, '0, 1'b0);
                    end else begin
                        n_state = BK_SCAN;
                    end
                end
            end
            BK_SCAN: begin
                // issue one slot read a cycle, compare it the cycle after
                if (!r_issue_done) begin
                    n_chk      = 1'b1;
                    n_chk_addr = r_idx;
                    if (r_idx == LAST) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (scan_end) begin
                    n_state = BK_IDLE;
                    n_chk   = 1'b0;
                    case (r_cur.kind)
                        KIND_SEND: begin
                            n_res_valid = 1'b1;
                            if (hit_now) begin
                                n_res = f_res(ACT_DATA, r_rd_mac, r_cur.ip,
                                              r_cur.ftype, r_cur.tag, r_cur.len,
                                              1'b0);
                            end else begin
                                // park the frame, replacing any earlier one
                                n_pend_ip   = r_cur.ip;
                                n_pend_type = r_cur.ftype;
                                n_pend_tag  = r_cur.tag;
                                n_pend_len  = r_cur.len;
                                n_res = f_res(ACT_ARP_REQ, BCAST_MAC, r_cur.ip,
                                              '0, '0, '0, 1'b1);
                            end
                        end
                        KIND_ARP_REPLY: begin
                            if (r_cur.to_us && !hit_now) begin
                                mem_we               = 1'b1;
                                n_valid[r_next_slot] = 1'b1;
                                n_next_slot = (r_next_slot == LAST) ? '0
                                                                    : r_next_slot + 1'b1;
                            end
                            if (r_pend_len != '0) begin
                                n_res_valid = 1'b1;
                                if ((r_cur.ip == r_pend_ip) && (hit_now || r_cur.to_us)) begin
                                    // release the parked frame
                                    n_res = f_res(ACT_DATA,
                                                  hit_now ? r_rd_mac : r_cur.mac,
                                                  r_pend_ip, r_pend_type, r_pend_tag,
                                                  r_pend_len, 1'b1);
                                    n_pend_ip   = '0;
                                    n_pend_type = '0;
                                    n_pend_tag  = '0;
                                    n_pend_len  = '0;
                                end else begin
                                    n_res = f_res(ACT_ARP_REQ, BCAST_MAC, r_pend_ip,
                                                  '0, '0, '0, 1'b0);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_chk        <= 1'b0;
            r_chk_addr   <= '0;
            r_valid      <= '0;
            r_next_slot  <= '0;
            r_pend_ip    <= '0;
            r_pend_type  <= '0;
            r_pend_tag   <= '0;
            r_pend_len   <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_issue_done <= n_issue_done;
            r_chk        <= n_chk;
            r_chk_addr   <= n_chk_addr;
            r_valid      <= n_valid;
            r_next_slot  <= n_next_slot;
            r_pend_ip    <= n_pend_ip;
            r_pend_type  <= n_pend_type;
            r_pend_tag   <= n_pend_tag;
            r_pend_len   <= n_pend_len;
            r_res_valid  <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cache_mem[r_next_slot] <= {r_cur.ip, r_cur.mac};
        end
        {r_rd_ip, r_rd_mac} <= r_cache_mem[r_idx];
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_ins_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(mem_we) |-> r_valid[$past(r_next_slot)])
        else $error("inserted slot not marked valid");

    a_slot_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_next_slot != $past(r_next_slot)))
        else $error("insert pointer did not advance");

    a_release_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_res.action == ACT_DATA) && r_res.was_queued)
            |-> (r_pend_len == '0))
        else $error("released frame still pending");

    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> ($past(scan_end) || $past(o_pop && (i_cmd.kind == KIND_ARP_REQ))))
        else $error("result word without a finished command");

endmodule
`default_nettype wire
